[rtl/core/hlp_pkg.sv]
// Shared types and constants for the 5x5 high-pass filter.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package hlp_pkg;

  localparam int PixW      = 8;
  localparam int Taps      = 5;
  localparam int RowW      = 12;
  localparam int LwW       = 11;
  localparam int FhW       = 13;
  localparam int DimW      = 13;
  localparam int CfgW      = 13;
  localparam int MinDim    = 5;
  localparam int MaxHeight = 4096;
  localparam int Offset    = 128;
  localparam int AccW      = 14;
  localparam int FifoDepth = 8;
  localparam int FifoAw    = 3;
  localparam int OccW      = 4;

  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PixW-1:0] pixel_in;
    logic            frame_start;
  } pix_t;

  typedef struct packed {
    logic [PixW-1:0] filtered_out;
    logic            row_end;
    logic            frame_end;
  } res_t;

  // one window column, index = row (0 is the oldest row)
  typedef logic [Taps-1:0][PixW-1:0] col_t;
  // whole window, index = column (4 is the newest column)
  typedef logic [Taps-1:0][Taps-1:0][PixW-1:0] win_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } flags_t;

endpackage

[rtl/core/hlp_cell.sv]
// One window column cell: holds five taps, takes the column of its neighbor.
// Depends on hlp_pkg.
`timescale 1ns / 1ps

module hlp_cell (
  input  logic          clk,
  input  logic          shift,
  input  hlp_pkg::col_t col_in,
  output hlp_pkg::col_t col_out
);

  hlp_pkg::col_t taps;

  always_ff @(posedge clk) begin
    if (shift) begin
      taps <= col_in;
    end
  end

  assign col_out = taps;

endmodule

[rtl/core/hlp_line_buf.sv]
// Line store: four rows packed into one word per column, registered read.
// Depends on hlp_pkg. A same-edge write to the read address is forwarded.
`timescale 1ns / 1ps

module hlp_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [4*hlp_pkg::PixW-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [4*hlp_pkg::PixW-1:0] wr_data
);

  logic [4*hlp_pkg::PixW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

[rtl/core/hlp_kernel.sv]
// Kernel stage: partial sums registered, then offset and clamp.
// Depends on hlp_pkg.
`timescale 1ns / 1ps

module hlp_kernel (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_v,
  input  hlp_pkg::win_t   win,
  input  hlp_pkg::flags_t flags,
  output logic            out_v,
  output hlp_pkg::res_t   res
);

  localparam int PW = hlp_pkg::PixW;
  localparam int AW = hlp_pkg::AccW;

  logic [PW+3:0]   cen;   // centre times 16
  logic [PW+2:0]   neg1;  // eight taps of weight -1
  logic [PW+1:0]   neg2;  // four taps of weight -2
  hlp_pkg::flags_t fl;

  logic [PW+3:0]   cen_next;
  logic [PW+2:0]   neg1_next;
  logic [PW+1:0]   neg2_next;
  logic signed [AW-1:0] acc;

  always_comb begin
    cen_next  = {win[2][2], 4'b0000};
    neg1_next = (PW+3)'(win[2][0]) + (PW+3)'(win[2][4]) + (PW+3)'(win[0][2])
              + (PW+3)'(win[4][2]) + (PW+3)'(win[1][1]) + (PW+3)'(win[1][3])
              + (PW+3)'(win[3][1]) + (PW+3)'(win[3][3]);
    neg2_next = (PW+2)'(win[2][1]) + (PW+2)'(win[2][3])
              + (PW+2)'(win[1][2]) + (PW+2)'(win[3][2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v) begin
      cen  <= cen_next;
      neg1 <= neg1_next;
      neg2 <= neg2_next;
      fl   <= flags;
    end
  end

  always_comb begin
    acc = signed'(AW'(cen)) + signed'(AW'(hlp_pkg::Offset))
        - signed'(AW'(neg1)) - signed'(AW'({neg2, 1'b0}));
    if (acc < 0) begin
      res.filtered_out = '0;
    end else if (acc > signed'(AW'(255))) begin
      res.filtered_out = '1;
    end else begin
      res.filtered_out = acc[PW-1:0];
    end
    res.row_end   = fl.row_end;
    res.frame_end = fl.frame_end;
  end

endmodule

[rtl/core/highpass_5x5_offset_clamp_filter.sv]
// A pixel passes stage 1, stage 2, the kernel and the result queue to res.
// Throughput: one pixel per cycle while pix_ready is high; the line store's
// single read and write ports are each used once per pixel, and an 8-entry
// result queue parts the two sides. Reset: counters to zero, line_width 640,
// frame_height 480, pipeline and queue empty; line store uncleared, undefined.
`timescale 1ns / 1ps

module highpass_5x5_offset_clamp_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pix_valid,
  output logic                      pix_ready,
  input  hlp_pkg::pix_t             pix,
  output logic                      res_valid,
  input  logic                      res_ready,
  output hlp_pkg::res_t             res,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [hlp_pkg::CfgW-1:0]  wr_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = hlp_pkg::PixW;
  localparam int DW = hlp_pkg::DimW;

  // configuration
  logic [hlp_pkg::LwW-1:0] line_width;
  logic [hlp_pkg::FhW-1:0] frame_height;
  logic [DW-1:0]           w_eff, h_eff, w_m1, h_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= hlp_pkg::LwW'(640);
      frame_height <= hlp_pkg::FhW'(480);
    end else if (wr_en) begin
      case (wr_index)
        hlp_pkg::REG_LINE_WIDTH:   line_width   <= wr_data[hlp_pkg::LwW-1:0];
        hlp_pkg::REG_FRAME_HEIGHT: frame_height <= wr_data[hlp_pkg::FhW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (DW'(line_width) < DW'(hlp_pkg::MinDim)) begin
      w_eff = DW'(hlp_pkg::MinDim);
    end else if (DW'(line_width) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(line_width);
    end
    if (DW'(frame_height) < DW'(hlp_pkg::MinDim)) begin
      h_eff = DW'(hlp_pkg::MinDim);
    end else if (DW'(frame_height) > DW'(hlp_pkg::MaxHeight)) begin
      h_eff = DW'(hlp_pkg::MaxHeight);
    end else begin
      h_eff = DW'(frame_height);
    end
    w_m1 = w_eff - DW'(1);
    h_m1 = h_eff - DW'(1);
  end

  // position counters
  logic [CW-1:0]            col_cnt, col_cnt_next, x;
  logic [hlp_pkg::RowW-1:0] row_cnt, row_cnt_next, y;
  logic                     last_col, last_row, produce, pix_xfer;

  assign pix_xfer = pix_valid && pix_ready;

  always_comb begin
    x        = pix.frame_start ? '0 : col_cnt;
    y        = pix.frame_start ? '0 : row_cnt;
    last_col = DW'(x) >= w_m1;
    last_row = DW'(y) >= h_m1;
    produce  = (DW'(x) >= DW'(4)) && (DW'(y) >= DW'(4));
    row_cnt_next = y;
    if (last_col) begin
      col_cnt_next = '0;
      row_cnt_next = last_row ? '0 : y + hlp_pkg::RowW'(1);
    end else begin
      col_cnt_next = x + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (pix_xfer) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // stage 1: line store read lands, column formed and written back
  logic                s1_v, s1_prod;
  logic [PW-1:0]       s1_pix;
  logic [CW-1:0]       s1_x;
  hlp_pkg::flags_t     s1_fl;
  logic [4*PW-1:0]     lb_rd, lb_wr;
  hlp_pkg::col_t       new_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= pix_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      s1_pix          <= pix.pixel_in;
      s1_x            <= x;
      s1_prod         <= produce;
      s1_fl.row_end   <= last_col;
      s1_fl.frame_end <= last_col && last_row;
    end
  end

  hlp_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (pix_xfer),
    .rd_addr (x),
    .rd_data (lb_rd),
    .wr_en   (s1_v),
    .wr_addr (s1_x),
    .wr_data (lb_wr)
  );

  // rows move up by one at this column; the new pixel becomes the newest row
  assign lb_wr   = {s1_pix, lb_rd[4*PW-1:PW]};
  assign new_col = {s1_pix, lb_rd};

  // window: chain of column cells, newest at index 4
  hlp_pkg::win_t win;

  for (genvar c = 0; c < hlp_pkg::Taps; c++) begin : g_cell
    hlp_pkg::col_t cin;
    if (c == hlp_pkg::Taps - 1) begin : g_head
      assign cin = new_col;
    end else begin : g_link
      assign cin = win[c+1];
    end
    hlp_cell u_cell (
      .clk     (clk),
      .shift   (s1_v),
      .col_in  (cin),
      .col_out (win[c])
    );
  end

  // stage 2: window holds this pixel's taps
  logic            s2_v;
  hlp_pkg::flags_t s2_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v && s1_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_fl <= s1_fl;
    end
  end

  logic          k_v;
  hlp_pkg::res_t k_res;

  hlp_kernel u_kernel (
    .clk   (clk),
    .rst   (rst),
    .in_v  (s2_v),
    .win   (win),
    .flags (s2_fl),
    .out_v (k_v),
    .res   (k_res)
  );

  // result queue; input is held off while in-flight items could overfill it
  hlp_pkg::res_t               fifo [hlp_pkg::FifoDepth];
  logic [hlp_pkg::FifoAw-1:0]  wptr, rptr;
  logic [hlp_pkg::OccW-1:0]    fcnt, inflight;
  logic                        res_xfer;

  assign res_xfer  = res_valid && res_ready;
  assign res_valid = (fcnt != '0);
  assign res       = fifo[rptr];
  assign inflight  = hlp_pkg::OccW'(s1_v) + hlp_pkg::OccW'(s2_v)
                   + hlp_pkg::OccW'(k_v) + fcnt;
  assign pix_ready = inflight < hlp_pkg::OccW'(hlp_pkg::FifoDepth);

  always_ff @(posedge clk) begin
    if (k_v) begin
      fifo[wptr] <= k_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fcnt <= '0;
    end else begin
      if (k_v) begin
        wptr <= wptr + hlp_pkg::FifoAw'(1);
      end
      if (res_xfer) begin
        rptr <= rptr + hlp_pkg::FifoAw'(1);
      end
      case ({k_v, res_xfer})
        2'b10:   fcnt <= fcnt + hlp_pkg::OccW'(1);
        2'b01:   fcnt <= fcnt - hlp_pkg::OccW'(1);
        default: fcnt <= fcnt;
      endcase
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for highpass_5x5_offset_clamp_filter: streams pixels,
// predicts each filtered result in-line and checks every result transfer.
// Depends on hlp_pkg (pix_t, res_t, register indexes) and the filter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_W          = 1024;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TOTAL_ITEMS    = 1000;
  localparam int RESET_GEOM_PX  = 120;

  localparam int LOG_KERNEL [5][5] = '{
    '{ 0,  0, -1,  0,  0},
    '{ 0, -1, -2, -1,  0},
    '{-1, -2, 16, -2, -1},
    '{ 0, -1, -2, -1,  0},
    '{ 0,  0, -1,  0,  0}
  };

  typedef enum int {PX_NOISE, PX_SMOOTH, PX_BRIGHT_DOTS, PX_DARK_DOTS} px_style_t;

  // directed rows: a stimulus pixel, plus a hand-worked result where one is due
  typedef struct packed {
    hlp_pkg::pix_t item;
    logic          check_want;
    hlp_pkg::res_t want;
  } dir_row_t;

  localparam dir_row_t D_START = '{item: '{8'd0, 1'b1}, check_want: 1'b0, want: '0};
  localparam dir_row_t D_ZERO  = '{item: '{8'd0, 1'b0}, check_want: 1'b0, want: '0};
  localparam dir_row_t D_PEAK  = '{item: '{8'd255, 1'b0}, check_want: 1'b0, want: '0};
  localparam dir_row_t D_MID   = '{item: '{8'd16, 1'b0}, check_want: 1'b0, want: '0};
  // bright centre on a dark 5x5 frame: saturates high, last of row and frame
  localparam dir_row_t D_LAST  = '{item: '{8'd0, 1'b0}, check_want: 1'b1,
                                   want: '{8'd255, 1'b1, 1'b1}};

  localparam dir_row_t DIRECTED [25] = '{
    D_START, D_ZERO, D_ZERO, D_ZERO, D_ZERO,
    D_ZERO,  D_ZERO, D_ZERO, D_ZERO, D_ZERO,
    D_ZERO,  D_ZERO, D_PEAK, D_ZERO, D_ZERO,
    D_ZERO,  D_ZERO, D_ZERO, D_ZERO, D_ZERO,
    D_ZERO,  D_ZERO, D_MID,  D_ZERO, D_LAST
  };

  logic                     clk;
  logic                     rst;
  logic                     pix_valid;
  logic                     pix_ready;
  hlp_pkg::pix_t            pix;
  logic                     res_valid;
  logic                     res_ready;
  hlp_pkg::res_t            res;
  logic                     wr_en;
  logic                     wr_index;
  logic [hlp_pkg::CfgW-1:0] wr_data;

  highpass_5x5_offset_clamp_filter #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  // predictor state
  bit [hlp_pkg::LwW-1:0]  cfg_width  = 11'd640;
  bit [hlp_pkg::FhW-1:0]  cfg_height = 13'd480;
  bit [hlp_pkg::PixW-1:0] line_rows [4][MAX_W];
  bit [hlp_pkg::PixW-1:0] window [5][5];
  int unsigned            col_cnt;
  int unsigned            row_cnt;

  hlp_pkg::res_t pending_results [$];

  int  mismatches;
  int  pixels_sent;
  int  results_seen;
  int  row_ends_seen;
  int  frame_ends_seen;
  int  geometries;
  int  idle_cycles;
  int  hold_left;
  bit  src_gaps;
  bit  sink_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_width(input bit [hlp_pkg::LwW-1:0] w);
    if (w < hlp_pkg::MinDim) return hlp_pkg::MinDim;
    if (w > MAX_W) return MAX_W;
    return 32'(w);
  endfunction

  function automatic int unsigned eff_height(input bit [hlp_pkg::FhW-1:0] h);
    if (h < hlp_pkg::MinDim) return hlp_pkg::MinDim;
    if (h > hlp_pkg::MaxHeight) return hlp_pkg::MaxHeight;
    return 32'(h);
  endfunction

  // Advances the filter state by one pixel; returns 1 when a result is due.
  function automatic bit predict_pixel(input hlp_pkg::pix_t p,
                                       output hlp_pkg::res_t out_res);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int          acc;
    bit [hlp_pkg::PixW-1:0] column [5];
    bit          last_col;
    bit          produced;
    w = eff_width(cfg_width);
    h = eff_height(cfg_height);
    out_res = '0;
    produced = 1'b0;
    if (p.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    x = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
    for (int r = 0; r < 4; r++) column[r] = line_rows[r][x];
    column[4] = p.pixel_in;
    for (int r = 0; r < 3; r++) line_rows[r][x] = line_rows[r+1][x];
    line_rows[3][x] = p.pixel_in;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) window[r][c] = window[r][c+1];
      window[r][4] = column[r];
    end
    if (col_cnt >= 4 && row_cnt >= 4) begin
      acc = hlp_pkg::Offset;
      for (int r = 0; r < 5; r++)
        for (int c = 0; c < 5; c++)
          acc += LOG_KERNEL[r][c] * int'(window[r][c]);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      last_col = col_cnt >= w - 1;
      out_res.filtered_out = acc[hlp_pkg::PixW-1:0];
      out_res.row_end = last_col;
      out_res.frame_end = last_col && row_cnt >= h - 1;
      produced = 1'b1;
    end
    if (col_cnt >= w - 1) begin
      col_cnt = 0;
      row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return produced;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [hlp_pkg::PixW-1:0] make_pixel(
      input px_style_t style, input logic [hlp_pkg::PixW-1:0] base);
    case (style)
      PX_SMOOTH:      return base + hlp_pkg::PixW'($urandom_range(0, 6));
      PX_BRIGHT_DOTS: return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
      PX_DARK_DOTS:   return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'hFF;
      default:        return hlp_pkg::PixW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [hlp_pkg::PixW-1:0] got,
                                 input logic [hlp_pkg::PixW-1:0] want);
    mismatches++;
    $display("MISMATCH at result %0d: %s got %0d, expected %0d",
             results_seen, what, got, want);
  endtask

  // One pixel transfer. Valid drops after the transfer only when a gap follows
  // or the phase ends, so valid stays high across back-to-back transfers.
  task automatic put_pixel(input hlp_pkg::pix_t p, input logic check_want,
                           input hlp_pkg::res_t want, input bit last);
    hlp_pkg::res_t predicted;
    bit            produced;
    int            gap;
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (!pix_ready);
    produced = predict_pixel(p, predicted);
    if (check_want) pending_results.push_back(want);
    else if (produced) pending_results.push_back(predicted);
    pixels_sent++;
    gap = pick_gap(src_gaps);
    if (gap > 0 || last) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stream_pixels(input int count, input px_style_t style,
                               input bit stray_starts);
    logic [hlp_pkg::PixW-1:0] base;
    hlp_pkg::pix_t p;
    base = hlp_pkg::PixW'($urandom_range(0, 249));
    for (int i = 0; i < count; i++) begin
      p.pixel_in = make_pixel(style, base);
      p.frame_start = (i == 0) || (stray_starts && $urandom_range(0, 149) == 0);
      put_pixel(p, 1'b0, '0, i == count - 1);
    end
  endtask

  // wait for every expected result, then let the pipeline empty out
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [hlp_pkg::LwW-1:0] w,
                              input logic [hlp_pkg::FhW-1:0] h);
    wr_en <= 1'b1;
    wr_index <= hlp_pkg::REG_LINE_WIDTH;
    wr_data <= hlp_pkg::CfgW'(w);
    @(posedge clk);
    wr_index <= hlp_pkg::REG_FRAME_HEIGHT;
    wr_data <= h;
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_width = w;
    cfg_height = h;
    geometries++;
  endtask

  // result side: random back-pressure, plus the long hold-off when requested
  initial begin : result_sink
    int   off_left;
    int   on_left;
    logic nxt;
    off_left = 0;
    on_left = 0;
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (off_left == 0 && on_left == 0) begin
        off_left = pick_gap(sink_gaps);
        on_left = $urandom_range(1, 24);
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (off_left > 0) begin
        off_left--;
        nxt = 1'b0;
      end else begin
        on_left--;
        nxt = 1'b1;
      end
      res_ready <= nxt;
    end
  end

  always @(posedge clk) begin : result_check
    hlp_pkg::res_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (res.row_end === 1'b1) row_ends_seen++;
      if (res.frame_end === 1'b1) frame_ends_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, filtered_out", res.filtered_out, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (res.filtered_out !== want.filtered_out)
          report_mismatch("filtered_out", res.filtered_out, want.filtered_out);
        if (res.row_end !== want.row_end)
          report_mismatch("row_end", hlp_pkg::PixW'(res.row_end),
                          hlp_pkg::PixW'(want.row_end));
        if (res.frame_end !== want.frame_end)
          report_mismatch("frame_end", hlp_pkg::PixW'(res.frame_end),
                          hlp_pkg::PixW'(want.frame_end));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (pix_valid && pix_ready) || (res_valid && res_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("highpass_5x5_offset_clamp_filter test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          count;
    int unsigned w_eff;
    int unsigned h_eff;
    logic [hlp_pkg::LwW-1:0] w_reg;
    logic [hlp_pkg::FhW-1:0] h_reg;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    wr_en = 1'b0;
    wr_index = hlp_pkg::REG_LINE_WIDTH;
    wr_data = '0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset geometry (640 x 480): part of the top border, no results due
    stream_pixels(RESET_GEOM_PX, PX_NOISE, 1'b0);

    // directed frame; both registers below range, so 5 x 5
    settle();
    set_geometry('0, '0);
    foreach (DIRECTED[i])
      put_pixel(DIRECTED[i].item, DIRECTED[i].check_want, DIRECTED[i].want, i == 24);

    // fill the result queue while the receiver holds off
    settle();
    set_geometry(11'd12, 13'd9);
    src_gaps = 1'b0;
    hold_left = HOLD_CYCLES;
    stream_pixels(2 * 12 * 9, PX_NOISE, 1'b0);

    while (pixels_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_reg = hlp_pkg::LwW'($urandom_range(0, 4));
        1:       w_reg = hlp_pkg::LwW'($urandom_range(13, 24));
        default: w_reg = hlp_pkg::LwW'($urandom_range(5, 12));
      endcase
      h_reg = ($urandom_range(0, 6) == 0) ? hlp_pkg::FhW'($urandom_range(0, 4))
                                          : hlp_pkg::FhW'($urandom_range(5, 9));
      w_eff = eff_width(w_reg);
      h_eff = eff_height(h_reg);
      count = (w_eff > 12 ? 1 : $urandom_range(1, 2)) * w_eff * h_eff
              + $urandom_range(0, 3 * w_eff);
      settle();
      set_geometry(w_reg, h_reg);
      src_gaps = $urandom_range(0, 3) != 0;
      sink_gaps = $urandom_range(0, 3) != 0;
      stream_pixels(count, px_style_t'($urandom_range(0, 3)), $urandom_range(0, 2) == 0);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixels over %0d geometries; %0d results checked (%0d row ends,",
             pixels_sent, geometries, results_seen, row_ends_seen);
    $display("%0d frame ends), with undersized geometry, frame wraps and a long stall",
             frame_ends_seen);
    if (mismatches == 0) begin
      $display("highpass_5x5_offset_clamp_filter test passed");
    end else begin
      $display("highpass_5x5_offset_clamp_filter test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/hlp_pkg.sv
rtl/core/hlp_cell.sv
rtl/core/hlp_line_buf.sv
rtl/core/hlp_kernel.sv
rtl/core/highpass_5x5_offset_clamp_filter.sv
tb/tb.sv
